// File: rtl/ptl_pkg.sv
// Shared types and constants for the LRU page table translator.
package ptl_pkg;

	localparam int PA_W     = 28;
	localparam int VA_W     = 32;
	localparam int CNT_W    = 32;
	localparam int CFG_W    = 5;
	localparam int IDX_W    = 6;
	localparam int FILL_W   = 7;
	localparam logic [CFG_W-1:0] OFFSET_MAX = 5'd24;

	localparam logic OP_TRANSLATE = 1'b0;
	localparam logic OP_SET_DIRTY = 1'b1;

	localparam logic CFG_OFFSET_BITS   = 1'b0;
	localparam logic CFG_FRAMES_IN_USE = 1'b1;

	typedef struct packed {
		logic            opcode;
		logic [VA_W-1:0] virtual_address;
		logic            is_write;
		logic [PA_W-1:0] frame_address;
	} ptl_req_t;

	typedef struct packed {
		logic             hit;
		logic [PA_W-1:0]  physical_address;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] fault_total;
		logic [CNT_W-1:0] disk_total;
	} ptl_rsp_t;

	// Search results rippling along the cell row.
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic [IDX_W-1:0] hit_rank;
		logic             lru;
		logic [IDX_W-1:0] lru_idx;
		logic             lru_dirty;
	} ptl_link_t;

	// Update command broadcast to every cell.
	typedef struct packed {
		logic              touch;
		logic [IDX_W-1:0]  touch_rank;
		logic [IDX_W-1:0]  top_rank;
		logic [IDX_W-1:0]  tgt;
		logic              load;
		logic              load_dirty;
		logic              mark;
		logic [IDX_W-1:0]  mark_idx;
		logic [FILL_W-1:0] filled;
	} ptl_upd_t;

endpackage

// File: rtl/ptl_cell.sv
// One frame of the page table: page tag, dirty bit and recency rank.
module ptl_cell import ptl_pkg::*; #(
	parameter int IDX    = 0,
	parameter int PAGE_W = 32,
	parameter int FW     = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ptl_upd_t          upd,
	input  logic [PAGE_W-1:0] page,
	input  ptl_link_t         link_in,
	output ptl_link_t         link_out
);

	logic [PAGE_W-1:0] page_q;
	logic              dirty_q;
	logic [FW-1:0]     rank_q;
	logic              filled;
	logic              is_tgt;
	logic              match;
	logic              lru;

	assign filled = FILL_W'(IDX) < upd.filled;
	assign is_tgt = IDX_W'(IDX) == upd.tgt;
	assign match  = filled && (page_q == page);
	assign lru    = filled && (rank_q == '0);

	// Pass the search along; tags are unique and ranks form a permutation.
	always_comb begin
		link_out = link_in;
		if (match) begin
			link_out.hit      = 1'b1;
			link_out.hit_idx  = IDX_W'(IDX);
			link_out.hit_rank = IDX_W'(rank_q);
		end
		if (lru) begin
			link_out.lru       = 1'b1;
			link_out.lru_idx   = IDX_W'(IDX);
			link_out.lru_dirty = dirty_q;
		end
	end

	always_ff @(posedge clk) begin
		if (upd.load && is_tgt) begin
			page_q <= page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= 1'b0;
			rank_q  <= '0;
		end else begin
			if (upd.load && is_tgt) begin
				dirty_q <= upd.load_dirty;
			end else if (upd.mark && (upd.mark_idx == IDX_W'(IDX))) begin
				dirty_q <= 1'b1;
			end
			if ((upd.touch || upd.load) && is_tgt) begin
				rank_q <= FW'(upd.top_rank);
			end else if (upd.touch && filled && (IDX_W'(rank_q) > upd.touch_rank)) begin
				rank_q <= rank_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/page_table_lru_translate.sv
// Top level of the fully associative page table with LRU replacement.
//
// Usage:
//   Request channel: drive req and raise start; the request is taken at a
//   rising edge where start is high and busy is low. busy is high for the
//   one cycle in which the taken request is worked on.
//   Result channel: done is high for exactly one cycle with rsp valid; the
//   receiver cannot stall, so capture rsp whenever done is seen.
//   Configuration: cfg_we with cfg_index and cfg_wdata writes offset_bits
//   (index 0) or frames_in_use (index 1) at that edge; write only when idle.
// Timing:
//   A taken request is held in the request register; from it the frame row
//   and the result register are updated together, and done then shows the
//   result. No new request is taken while busy is high, so only one request
//   is in work at a time: the request register plus the single update pass.
//   Within that pass, the match and LRU search ripple through the chain of
//   frame cells and the update command is broadcast back to all of them.
// Reset: counters, fill count, dirty bits and ranks clear; offset_bits
//   returns to 12 and frames_in_use to 16. Frame tags are not cleared:
//   only frames below the fill count are ever searched.
module page_table_lru_translate import ptl_pkg::*; #(
	parameter int FRAMES    = 16,
	parameter int ADDR_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ptl_req_t         req,
	output logic             done,
	output ptl_rsp_t         rsp,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int FW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CFW  = $clog2(FRAMES + 1);
	localparam int PG_W = (ADDR_BITS < VA_W) ? ADDR_BITS : VA_W;

	logic [CFG_W-1:0] offset_bits_q;
	logic [CFG_W-1:0] frames_in_use_q;
	logic [CFW-1:0]   filled_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic [CNT_W-1:0] fault_cnt_q;
	logic [CNT_W-1:0] disk_cnt_q;

	logic     valid_s1;
	ptl_req_t req_s1;
	logic     done_q;
	ptl_rsp_t rsp_q;

	ptl_link_t link [FRAMES+1];
	ptl_link_t found;
	ptl_upd_t  upd;

	logic [CFG_W-1:0] ob;
	logic [VA_W-1:0]  va;
	logic [VA_W-1:0]  page_full;
	logic [PG_W-1:0]  page;
	logic [VA_W-1:0]  off;
	logic [PA_W-1:0]  fa_idx;
	logic [7:0]       limit;
	logic             translate;
	logic             set_dirty;
	logic             can_fill;
	logic             do_fill;
	logic             do_evict;
	logic [CNT_W-1:0] disk_next;

	assign busy = valid_s1;
	assign done = done_q;
	assign rsp  = rsp_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q   <= 5'd12;
			frames_in_use_q <= 5'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OFFSET_BITS:   offset_bits_q   <= cfg_wdata;
				CFG_FRAMES_IN_USE: frames_in_use_q <= cfg_wdata;
			endcase
		end
	end

	// Hold the taken request for its update cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	// Split the address; offsets wider than 24 bits clamp to 24.
	always_comb begin
		ob        = (offset_bits_q > OFFSET_MAX) ? OFFSET_MAX : offset_bits_q;
		va        = VA_W'(req_s1.virtual_address[PG_W-1:0]);
		page_full = va >> ob;
		page      = page_full[PG_W-1:0];
		off       = va & ((VA_W'(1) << ob) - VA_W'(1));
		fa_idx    = req_s1.frame_address >> ob;
	end

	// Clamp the frame limit to 1..FRAMES.
	always_comb begin
		if (frames_in_use_q == '0) begin
			limit = 8'd1;
		end else if (8'(frames_in_use_q) > 8'(FRAMES)) begin
			limit = 8'(FRAMES);
		end else begin
			limit = 8'(frames_in_use_q);
		end
	end

	// Row of frame cells; the search ripples from cell 0 upward.
	assign link[0] = '0;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		ptl_cell #(
			.IDX    (i),
			.PAGE_W (PG_W),
			.FW     (FW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.upd      (upd),
			.page     (page),
			.link_in  (link[i]),
			.link_out (link[i+1])
		);
	end

	assign found = link[FRAMES];

	// Decide the update: refresh on hit, fill a free frame, evict LRU, or mark a frame dirty.
	always_comb begin
		translate = valid_s1 && (req_s1.opcode == OP_TRANSLATE);
		set_dirty = valid_s1 && (req_s1.opcode == OP_SET_DIRTY);
		can_fill  = 8'(filled_q) < limit;
		do_fill   = translate && !found.hit && can_fill;
		do_evict  = translate && !found.hit && !can_fill;

		upd            = '0;
		upd.filled     = FILL_W'(filled_q);
		upd.load_dirty = req_s1.is_write;
		upd.top_rank   = IDX_W'(filled_q - 1'b1);
		upd.mark       = set_dirty && (fa_idx < PA_W'(filled_q));
		upd.mark_idx   = fa_idx[IDX_W-1:0];
		if (translate && found.hit) begin
			upd.touch      = 1'b1;
			upd.tgt        = found.hit_idx;
			upd.touch_rank = found.hit_rank;
		end else if (do_fill) begin
			upd.load     = 1'b1;
			upd.tgt      = IDX_W'(filled_q);
			upd.top_rank = IDX_W'(filled_q);
		end else if (do_evict) begin
			upd.touch      = 1'b1;
			upd.load       = 1'b1;
			upd.tgt        = found.lru_idx;
			upd.touch_rank = '0;
		end

		// A dirty victim costs a write-back on top of the fault read.
		disk_next = disk_cnt_q;
		if (translate && !found.hit) begin
			disk_next = disk_cnt_q + 1'b1 + CNT_W'(do_evict && found.lru_dirty);
		end
	end

	// Advance counters and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q    <= '0;
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
			disk_cnt_q  <= '0;
		end else begin
			if (do_fill) begin
				filled_q <= filled_q + 1'b1;
			end
			if (translate && found.hit) begin
				hit_cnt_q <= hit_cnt_q + 1'b1;
			end
			if (translate && !found.hit) begin
				fault_cnt_q <= fault_cnt_q + 1'b1;
			end
			disk_cnt_q <= disk_next;
		end
	end

	// Register the result; set-dirty reports zero hit and address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q.hit              <= translate && found.hit;
			rsp_q.physical_address <= translate
				? ((PA_W'(upd.tgt) << ob) | PA_W'(off)) : '0;
			rsp_q.hit_total   <= hit_cnt_q + CNT_W'(translate && found.hit);
			rsp_q.fault_total <= fault_cnt_q + CNT_W'(translate && !found.hit);
			rsp_q.disk_total  <= disk_next;
		end
	end

endmodule

// File: rtl/ptl_checker.sv
// Port-level checks for the page table translator, bound to the top level.
module ptl_checker import ptl_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input ptl_rsp_t rsp
);

	// A taken request occupies exactly one work cycle.
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but block not busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("work cycle did not end in a result");

	// No result without a work cycle before it.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request");

	// A hit moves the hit count past the one in a back-to-back previous result.
	a_hit_total: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.hit |-> rsp.hit_total != $past(rsp.hit_total, 2) || !$past(done, 2))
		else $error("hit did not advance hit count");

endmodule

bind page_table_lru_translate ptl_checker u_ptl_checker (.*);

// File: test/tb.sv
// Self-checking testbench for the LRU page table translator.
module tb;
	import ptl_pkg::*;

	localparam int FRAMES       = 16;
	localparam int CYCLE_LIMIT  = 120000;
	localparam int SETTLE       = 4;
	localparam int PHASE_ITEMS  = 95;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic             busy;
	ptl_req_t         req       = '0;
	logic             done;
	ptl_rsp_t         rsp;
	logic             cfg_we    = 1'b0;
	logic             cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	page_table_lru_translate #(
		.FRAMES(FRAMES),
		.ADDR_BITS(VA_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Requests waiting to be offered, and results the table owes us.
	ptl_req_t request_q[$];
	ptl_rsp_t owed_rsp[$];

	int          errors = 0;
	int          gap_max = 0;
	int          hold_cnt = 0;
	int unsigned cycle_cnt = 0;
	ptl_rsp_t    want;

	// Shadow copy of the page table: registers, frames, ranks and counters.
	logic [CFG_W-1:0] cfg_offset_bits = 5'd12;
	logic [CFG_W-1:0] cfg_frame_limit = 5'd16;
	logic [VA_W-1:0]  frame_page[FRAMES];
	logic             frame_dirty[FRAMES];
	int               frame_rank[FRAMES];
	int               filled = 0;
	logic [CNT_W-1:0] hit_cnt = '0;
	logic [CNT_W-1:0] fault_cnt = '0;
	logic [CNT_W-1:0] disk_cnt = '0;

	initial begin
		for (int i = 0; i < FRAMES; i++) begin
			frame_page[i]  = '0;
			frame_dirty[i] = 1'b0;
			frame_rank[i]  = 0;
		end
	end

	initial begin
		forever #5 clk = ~clk;
	end

	// Give frame f the top rank; everything ranked above it slides down one.
	function automatic void promote_frame(int f);
		int old_rank;
		old_rank = frame_rank[f];
		for (int i = 0; i < filled; i++)
			if (frame_rank[i] > old_rank)
				frame_rank[i]--;
		frame_rank[f] = filled - 1;
	endfunction

	// Apply one request to the shadow table and return the result it owes.
	function automatic ptl_rsp_t translate_and_update(ptl_req_t r);
		ptl_rsp_t        o;
		int              ob, lim, f;
		logic [VA_W-1:0] pg, off;
		logic [63:0]     pa;
		bit              found;
		ob = (cfg_offset_bits > OFFSET_MAX) ? int'(OFFSET_MAX) : int'(cfg_offset_bits);
		o = '0;
		f = 0;
		found = 1'b0;
		if (r.opcode == OP_SET_DIRTY) begin
			// Frames not yet filled ignore the mark.
			f = int'(r.frame_address >> ob);
			if (f < filled)
				frame_dirty[f] = 1'b1;
		end else begin
			pg  = r.virtual_address >> ob;
			off = r.virtual_address & ((32'd1 << ob) - 32'd1);
			for (int i = 0; i < filled; i++) begin
				if (frame_page[i] == pg) begin
					f = i;
					found = 1'b1;
					break;
				end
			end
			if (found) begin
				// Write hit leaves the dirty bit alone.
				o.hit = 1'b1;
				hit_cnt++;
				promote_frame(f);
			end else begin
				fault_cnt++;
				disk_cnt++;
				lim = (cfg_frame_limit == 0) ? 1 :
					(cfg_frame_limit > FRAMES) ? FRAMES : int'(cfg_frame_limit);
				if (filled < lim) begin
					f = filled;
					filled++;
					frame_rank[f] = filled - 1;
				end else begin
					// Evict the least recent of all filled frames, even past the limit.
					for (int i = 0; i < filled; i++) begin
						if (frame_rank[i] == 0) begin
							f = i;
							break;
						end
					end
					if (frame_dirty[f])
						disk_cnt++;
					promote_frame(f);
				end
				frame_page[f]  = pg;
				frame_dirty[f] = r.is_write;
			end
			pa = (64'(f) << ob) | 64'(off);
			o.physical_address = pa[PA_W-1:0];
		end
		o.hit_total   = hit_cnt;
		o.fault_total = fault_cnt;
		o.disk_total  = disk_cnt;
		return o;
	endfunction

	task automatic check_field(string name, logic [CNT_W-1:0] exp_v, logic [CNT_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	// Driver: predict each request as it is taken, then offer the next one
	// after its drawn gap. Hold start and req while busy blocks the request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				owed_rsp.insert(owed_rsp.size(), translate_and_update(req));
			if (!start || !busy) begin
				if (hold_cnt != 0) begin
					hold_cnt <= hold_cnt - 1;
					start <= 1'b0;
				end else if (request_q.size() != 0) begin
					req <= request_q.pop_front();
					start <= 1'b1;
					hold_cnt <= $urandom_range(gap_max, 0);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: done marks the result for one cycle only, so take it
	// whenever done is seen and match it against the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (owed_rsp.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %p", $time, rsp);
				errors++;
			end else begin
				want = owed_rsp.pop_front();
				check_field("hit", CNT_W'(want.hit), CNT_W'(rsp.hit));
				check_field("physical_address", CNT_W'(want.physical_address),
					CNT_W'(rsp.physical_address));
				check_field("hit_total", want.hit_total, rsp.hit_total);
				check_field("fault_total", want.fault_total, rsp.fault_total);
				check_field("disk_total", want.disk_total, rsp.disk_total);
			end
		end
	end

	// Watchdog: a stuck handshake or a missing result ends here.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Wait until every request is taken and every result is back, then let
	// the row settle. Check at the falling edge so the driver's updates are in.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (request_q.size() != 0 || start || owed_rsp.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_OFFSET_BITS)
			cfg_offset_bits = val;
		else
			cfg_frame_limit = val;
	endtask

	// Drain, then rewrite both registers.
	task automatic configure(logic [CFG_W-1:0] ob, logic [CFG_W-1:0] lim);
		wait_idle();
		write_reg(CFG_OFFSET_BITS, ob);
		write_reg(CFG_FRAMES_IN_USE, lim);
	endtask

	task automatic push_translate(logic [VA_W-1:0] va, logic wr);
		ptl_req_t r;
		r.opcode          = OP_TRANSLATE;
		r.virtual_address = va;
		r.is_write        = wr;
		r.frame_address   = PA_W'($urandom);
		request_q.insert(request_q.size(), r);
	endtask

	task automatic push_set_dirty(logic [PA_W-1:0] fa);
		ptl_req_t r;
		r.opcode          = OP_SET_DIRTY;
		r.virtual_address = $urandom;
		r.is_write        = $urandom_range(1, 0);
		r.frame_address   = fa;
		request_q.insert(request_q.size(), r);
	endtask

	// Random phase: mostly pages from a pool a little larger than the frame
	// limit, so hits, fills and evictions all happen; the rest are stray
	// addresses and dirty marks, some aimed at frames, some anywhere.
	task automatic run_phase(int n, int gap);
		logic [VA_W-1:0] pool[$];
		logic [VA_W-1:0] mask, va;
		int              ob, lim, pick;
		ob = (cfg_offset_bits > OFFSET_MAX) ? int'(OFFSET_MAX) : int'(cfg_offset_bits);
		lim = (cfg_frame_limit == 0) ? 1 :
			(cfg_frame_limit > FRAMES) ? FRAMES : int'(cfg_frame_limit);
		mask = (32'd1 << ob) - 32'd1;
		repeat (lim + $urandom_range(3, 1)) pool.insert(pool.size(), $urandom);
		gap_max = gap;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99, 0);
			va = $urandom;
			if (pick < 9)
				push_set_dirty(PA_W'((32'($urandom_range(FRAMES + 1, 0)) << ob) | (va & mask)));
			else if (pick < 12)
				push_set_dirty(PA_W'($urandom));
			else if (pick < 88)
				push_translate((pool[$urandom_range(pool.size() - 1, 0)] & ~mask) | (va & mask),
					$urandom_range(1, 0));
			else
				push_translate(va, $urandom_range(1, 0));
		end
	endtask

	initial begin
		logic [CFG_W-1:0] ob_set[8];
		logic [CFG_W-1:0] lim_set[8];
		ob_set  = '{5'd12, 5'd0, 5'd24, 5'd31, 5'd1, 5'd25, 5'd4, 5'd16};
		lim_set = '{5'd16, 5'd1, 5'd16, 5'd0, 5'd4, 5'd31, 5'd3, 5'd17};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset settings: miss, write hit, top address, dirty marks
		// on a filled frame, an unfilled frame and the top frame address.
		gap_max = 0;
		push_translate(32'h0000_0000, 1'b0);
		push_translate(32'h0000_0FFF, 1'b1);
		push_translate(32'hFFFF_FFFF, 1'b1);
		push_set_dirty(28'h000_0000);
		push_set_dirty(28'h000_5123);
		push_set_dirty(28'hFFF_FFFF);
		push_translate(32'h1234_5678, 1'b0);

		// Zero offset width and a limit below the filled count: evict dirty, then clean.
		configure(5'd0, 5'd2);
		push_translate(32'h0000_0000, 1'b0);
		push_translate(32'h0000_0007, 1'b1);
		push_translate(32'h0000_0009, 1'b0);
		push_set_dirty(28'h000_0002);

		// Offset width above the cap and a zero frame limit.
		configure(5'd31, 5'd0);
		push_translate(32'hFF00_0001, 1'b0);
		push_translate(32'hFFAB_CDEF, 1'b1);
		push_translate(32'h0100_0000, 1'b1);
		push_set_dirty(28'hFFF_FFFF);

		// Frame limit above the table size.
		configure(5'd24, 5'd31);
		push_translate(32'h7F00_0000, 1'b0);
		push_translate(32'h7FFF_FFFF, 1'b0);

		// Random phases: fixed corners first, then random settings; every third
		// phase sends back-to-back requests, the others gappy ones.
		for (int p = 0; p < 12; p++) begin
			if (p < 8)
				configure(ob_set[p], lim_set[p]);
			else
				configure(CFG_W'($urandom), CFG_W'($urandom));
			run_phase(PHASE_ITEMS, (p % 3 == 0) ? 0 : 11);
		end

		wait_idle();
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
